FILE: rtl/sirp_pkg.sv
// Package for the seek index range planner: widths, request and status codes,
// and the sequencer state type. No dependencies.
package sirp_pkg;

    localparam int MaxBlocks  = 1024;
    localparam int IdxBits    = 10;
    localparam int CntBits    = 11;
    localparam int MaxSpan    = 64;
    localparam int OffBits    = 48;

    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_QUERY  = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_DST      = 3'd2,
        ST_PAST_END = 3'd3,
        ST_FULL     = 3'd4,
        ST_SPAN     = 3'd5,
        ST_OVERFLOW = 3'd6
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SRCH1,
        S_WAIT1,
        S_STEP1,
        S_SRCH2,
        S_WAIT2,
        S_STEP2,
        S_SPANCHK,
        S_EMIT_RD,
        S_EMIT_WAIT,
        S_EMIT
    } state_t;

    localparam logic [2:0] RegBase = 3'd0;

    // One stored index entry.
    typedef struct packed {
        logic [OffBits-1:0] comp_start;
        logic [31:0]        cbytes;
        logic [OffBits-1:0] decomp_end;
        logic [31:0]        dbytes;
    } entry_t;

    // Memory access bundle from the sequencer.
    typedef struct packed {
        logic               wr_en;
        logic [IdxBits-1:0] wr_addr;
        entry_t             wr_data;
        logic [IdxBits-1:0] rd_addr;
    } mem_req_t;

endpackage

FILE: rtl/sirp_entry_ram.sv
// Synchronous single-port-write, single-port-read entry memory of the index.
// Depends on sirp_pkg for the entry layout and depth.
module sirp_entry_ram (
    input  logic               clk,
    input  sirp_pkg::mem_req_t req,
    output sirp_pkg::entry_t   rd_data
);
    import sirp_pkg::*;

    entry_t mem [MaxBlocks];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_data <= mem[req.rd_addr];
    end
endmodule

FILE: rtl/sirp_seq.sv
// Request sequencer: append, clear, range checks, binary searches and plan emission.
// Depends on sirp_pkg; reads and writes the index through sirp_entry_ram.
module sirp_seq (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [1:0]                   req_type,
    input  logic [31:0]                  entry_cbytes,
    input  logic [31:0]                  entry_dbytes,
    input  logic [sirp_pkg::OffBits-1:0] range_offset,
    input  logic [sirp_pkg::OffBits-1:0] range_len,
    input  logic [sirp_pkg::OffBits-1:0] dest_room,
    input  logic [31:0]                  base_comp_offset,
    input  logic                         base_wr,
    output logic                         busy,
    output sirp_pkg::mem_req_t           mem_req,
    input  sirp_pkg::entry_t             rd_data,
    output logic                         valid,
    output logic [2:0]                   status,
    output logic [9:0]                   block_index,
    output logic [sirp_pkg::OffBits-1:0] comp_offset,
    output logic [31:0]                  blk_cbytes,
    output logic [31:0]                  skip_bytes,
    output logic [31:0]                  copy_bytes,
    output logic [sirp_pkg::OffBits-1:0] dst_offset,
    output logic                         last
);
    import sirp_pkg::*;

    state_t state_reg, state_next;
    logic [CntBits-1:0] count_reg;
    logic [OffBits-1:0] comp_run_reg, decomp_tot_reg;
    logic [OffBits-1:0] off_reg, len_reg, cap_reg, end_reg, rem_reg, dpos_reg;
    logic [CntBits-1:0] lo_reg, hi_reg, first_reg, final_reg, cur_reg;
    logic [CntBits-1:0] mid;
    logic [OffBits:0]   csum, dsum, qend;
    logic               hit;
    logic [OffBits-1:0] bstart, skip_w, avail_w, copy_w;
    logic [CntBits-1:0] span;

    assign mid  = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign csum = {1'b0, comp_run_reg} + {{(OffBits-31){1'b0}}, entry_cbytes};
    assign dsum = {1'b0, decomp_tot_reg} + {{(OffBits-31){1'b0}}, entry_dbytes};
    assign qend = {1'b0, off_reg} + {1'b0, len_reg};
    assign hit  = rd_data.decomp_end <= end_reg;
    assign span = final_reg - first_reg;

    // Per-block plan values from the entry just read.
    always_comb
    begin
        bstart  = rd_data.decomp_end - {{(OffBits-32){1'b0}}, rd_data.dbytes};
        skip_w  = (off_reg > bstart) ? off_reg - bstart : '0;
        avail_w = ({{(OffBits-32){1'b0}}, rd_data.dbytes} > skip_w)
                  ? {{(OffBits-32){1'b0}}, rd_data.dbytes} - skip_w : '0;
        copy_w  = (avail_w < rem_reg) ? avail_w : rem_reg;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start && req_type == REQ_QUERY)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (len_reg == '0 || cap_reg < len_reg
                    || qend > {1'b0, decomp_tot_reg})
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_SRCH1;
                end
            end
            S_SRCH1:     state_next = (lo_reg < hi_reg) ? S_WAIT1 : S_SRCH2;
            S_WAIT1:     state_next = S_STEP1;
            S_STEP1:     state_next = S_SRCH1;
            S_SRCH2:     state_next = (lo_reg < hi_reg) ? S_WAIT2 : S_SPANCHK;
            S_WAIT2:     state_next = S_STEP2;
            S_STEP2:     state_next = S_SRCH2;
            S_SPANCHK:
            begin
                if (final_reg >= count_reg || first_reg > final_reg
                    || span >= CntBits'(MaxSpan))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_EMIT_RD;
                end
            end
            S_EMIT_RD:   state_next = S_EMIT_WAIT;
            S_EMIT_WAIT: state_next = S_EMIT;
            S_EMIT:      state_next = (cur_reg == final_reg) ? S_IDLE : S_EMIT_RD;
            default:     state_next = S_IDLE;
        endcase
    end

    // Memory port control. The probe address is held through the wait cycle
    // so that the step cycle sees the entry at mid.
    always_comb
    begin
        mem_req = '0;
        mem_req.wr_addr = count_reg[IdxBits-1:0];
        mem_req.wr_data.comp_start  = comp_run_reg;
        mem_req.wr_data.cbytes      = entry_cbytes;
        mem_req.wr_data.decomp_end  = dsum[OffBits-1:0];
        mem_req.wr_data.dbytes      = entry_dbytes;
        mem_req.wr_en = state_reg == S_IDLE && start && req_type == REQ_APPEND
                        && count_reg != CntBits'(MaxBlocks)
                        && !csum[OffBits] && !dsum[OffBits];
        case (state_reg)
            S_SRCH1, S_WAIT1, S_SRCH2, S_WAIT2: mem_req.rd_addr = mid[IdxBits-1:0];
            default:                            mem_req.rd_addr = cur_reg[IdxBits-1:0];
        endcase
    end

    assign busy = state_reg != S_IDLE;

    // Registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            comp_run_reg   <= OffBits'(16);
            decomp_tot_reg <= '0;
            valid          <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid     <= 1'b0;
            if (base_wr && count_reg == '0)
            begin
                comp_run_reg <= {{(OffBits-32){1'b0}}, base_comp_offset};
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        valid <= req_type != REQ_NONE;
                        if (req_type == REQ_CLEAR)
                        begin
                            count_reg      <= '0;
                            decomp_tot_reg <= '0;
                            comp_run_reg   <= {{(OffBits-32){1'b0}}, base_comp_offset};
                        end
                        else if (mem_req.wr_en)
                        begin
                            count_reg      <= count_reg + 1'b1;
                            comp_run_reg   <= csum[OffBits-1:0];
                            decomp_tot_reg <= dsum[OffBits-1:0];
                        end
                        if (req_type == REQ_QUERY)
                        begin
                            valid <= 1'b0;
                        end
                    end
                end
                S_CHECK:
                begin
                    if (state_next == S_IDLE)
                    begin
                        valid <= 1'b1;
                    end
                end
                S_SPANCHK:
                begin
                    if (state_next == S_IDLE)
                    begin
                        valid <= 1'b1;
                    end
                end
                S_EMIT:
                begin
                    valid <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                off_reg <= range_offset;
                len_reg <= range_len;
                cap_reg <= dest_room;
                end_reg <= range_offset;
                lo_reg  <= '0;
                hi_reg  <= count_reg;
                status      <= ST_OK;
                block_index <= '0;
                comp_offset <= '0;
                blk_cbytes  <= '0;
                skip_bytes  <= '0;
                copy_bytes  <= '0;
                dst_offset  <= '0;
                last        <= 1'b1;
                if (req_type == REQ_APPEND)
                begin
                    if (count_reg == CntBits'(MaxBlocks))
                    begin
                        status <= ST_FULL;
                    end
                    else if (csum[OffBits] || dsum[OffBits])
                    begin
                        status <= ST_OVERFLOW;
                    end
                    else
                    begin
                        block_index <= count_reg[IdxBits-1:0];
                        comp_offset <= comp_run_reg;
                        blk_cbytes  <= entry_cbytes;
                        copy_bytes  <= entry_dbytes;
                        dst_offset  <= decomp_tot_reg;
                    end
                end
            end
            S_CHECK:
            begin
                status <= (len_reg == '0) ? ST_EMPTY
                        : (cap_reg < len_reg) ? ST_DST : ST_PAST_END;
            end
            S_STEP1, S_STEP2:
            begin
                if (hit)
                begin
                    lo_reg <= mid + 1'b1;
                end
                else
                begin
                    hi_reg <= mid;
                end
            end
            S_SRCH1:
            begin
                if (lo_reg >= hi_reg)
                begin
                    first_reg <= lo_reg;
                    lo_reg    <= '0;
                    hi_reg    <= count_reg;
                    end_reg   <= qend[OffBits-1:0] - 1'b1;
                end
            end
            S_SRCH2:
            begin
                final_reg <= lo_reg;
            end
            S_SPANCHK:
            begin
                status   <= ST_SPAN;
                cur_reg  <= first_reg;
                rem_reg  <= len_reg;
                dpos_reg <= '0;
            end
            S_EMIT:
            begin
                status      <= ST_OK;
                block_index <= cur_reg[IdxBits-1:0];
                comp_offset <= rd_data.comp_start;
                blk_cbytes  <= rd_data.cbytes;
                skip_bytes  <= skip_w[31:0];
                copy_bytes  <= copy_w[31:0];
                dst_offset  <= dpos_reg;
                last        <= cur_reg == final_reg;
                dpos_reg    <= dpos_reg + copy_w;
                rem_reg     <= rem_reg - copy_w;
                cur_reg     <= cur_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end
endmodule

FILE: rtl/seek_index_range_planner_core.sv
// Top level of the seek index range planner: APB register, sequencer, memory.
// Depends on sirp_pkg, sirp_seq and sirp_entry_ram.
// Clear and append: accepted every cycle while idle, answered the cycle after.
// Queries: a check state that answers refusals, then two binary searches
// of SRCH, WAIT and STEP states per step, at most ceil(log2(count+1)) steps
// each, a span check, and EMIT_RD, EMIT_WAIT and EMIT states per planned block.
// Reset: empty index, base offset 16; the receiver cannot stall results.
module seek_index_range_planner_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  logic [1:0]   req_type,
    input  logic [31:0]  entry_cbytes,
    input  logic [31:0]  entry_dbytes,
    input  logic [47:0]  range_offset,
    input  logic [47:0]  range_len,
    input  logic [47:0]  dest_room,
    output logic         strobe,
    output logic [2:0]   status,
    output logic [9:0]   block_index,
    output logic [47:0]  comp_offset,
    output logic [31:0]  blk_cbytes,
    output logic [31:0]  skip_bytes,
    output logic [31:0]  copy_bytes,
    output logic [47:0]  dst_offset,
    output logic         last,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import sirp_pkg::*;

    logic [31:0] base_reg;
    logic        base_wr;
    mem_req_t    mem_req;
    entry_t      rd_data;

    assign pready  = 1'b1;
    assign base_wr = psel && penable && pwrite && paddr == RegBase;
    assign prdata  = (paddr == RegBase) ? base_reg : '0;

    // Base offset register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= 32'd16;
        end
        else if (base_wr)
        begin
            base_reg <= pwdata;
        end
    end

    sirp_seq u_seq (
        .clk, .rst_n, .start, .req_type, .entry_cbytes, .entry_dbytes,
        .range_offset, .range_len, .dest_room,
        .base_comp_offset(base_wr ? pwdata : base_reg), .base_wr,
        .busy, .mem_req, .rd_data, .valid(strobe), .status, .block_index,
        .comp_offset, .blk_cbytes, .skip_bytes, .copy_bytes, .dst_offset, .last
    );

    sirp_entry_ram u_ram (
        .clk, .req(mem_req), .rd_data
    );
endmodule

FILE: rtl/sirp_checker.sv
// Port-level checker for the seek index range planner, bound to the top level.
// Depends on seek_index_range_planner_core ports and sirp_pkg codes.
module sirp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] req_type,
    input logic       strobe,
    input logic [2:0] status,
    input logic       last,
    input logic       pready
);
    import sirp_pkg::*;

    // A clear or append transaction answers on the next cycle.
    a_quick: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (req_type == REQ_CLEAR || req_type == REQ_APPEND)
        |=> strobe && last)
        else $error("no result after clear or append");

    // Error results always close the request.
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && status != ST_OK |-> last)
        else $error("error result without last");

    // The status code stays in its range.
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> status <= ST_OVERFLOW)
        else $error("status out of range");

    // The register port never waits.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");
endmodule

bind seek_index_range_planner_core sirp_checker u_sirp_checker (
    .clk, .rst_n, .start, .busy, .req_type, .strobe, .status, .last, .pready
);

FILE: bench/sirp_plan_checker.sv
`timescale 1ns / 1ps
// Checker for the seek index range planner: watches the request, result and APB
// channels, predicts every result and compares it. Depends on sirp_pkg only.
module sirp_plan_checker
    import sirp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic         busy,
    input  logic [1:0]   req_type,
    input  logic [31:0]  entry_cbytes,
    input  logic [31:0]  entry_dbytes,
    input  logic [47:0]  range_offset,
    input  logic [47:0]  range_len,
    input  logic [47:0]  dest_room,
    input  logic         strobe,
    input  logic [2:0]   status,
    input  logic [9:0]   block_index,
    input  logic [47:0]  comp_offset,
    input  logic [31:0]  blk_cbytes,
    input  logic [31:0]  skip_bytes,
    input  logic [31:0]  copy_bytes,
    input  logic [47:0]  dst_offset,
    input  logic         last,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         pready,
    output int           errors,
    output int           pending,
    output int           plans_seen,
    output logic [10:0]  index_count,
    output logic [47:0]  index_total
);

    typedef struct packed {
        logic [2:0]  st;
        logic [9:0]  idx;
        logic [47:0] coff;
        logic [31:0] csz;
        logic [31:0] skip;
        logic [31:0] copy;
        logic [47:0] doff;
        logic        lst;
    } plan_t;

    plan_t       plan_q[$];
    logic [31:0] base_off;
    logic [10:0] n_entries;
    logic [47:0] comp_run;
    logic [47:0] decomp_run;
    logic [47:0] start_tab[MaxBlocks];
    logic [31:0] csize_tab[MaxBlocks];
    logic [47:0] dend_tab[MaxBlocks];
    logic [31:0] dsize_tab[MaxBlocks];

    assign pending     = plan_q.size();
    assign index_count = n_entries;
    assign index_total = decomp_run;

    function automatic plan_t mk_plan(status_t st, logic [9:0] idx, logic [47:0] coff,
                                      logic [31:0] csz, logic [31:0] skip,
                                      logic [31:0] copy, logic [47:0] doff, logic lst);
        plan_t p;
        p = '{st, idx, coff, csz, skip, copy, doff, lst};
        return p;
    endfunction

    // First block whose decompressed end lies above pos.
    function automatic int locate_block(logic [63:0] pos);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = n_entries;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if ({16'd0, dend_tab[mid]} <= pos)
                lo = mid + 1;
            else
                hi = mid;
        end
        return lo;
    endfunction

    task automatic report(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t ns: mismatch on %s: expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            errors++;
        end
    endtask

    // Append: store the entry and extend the running sums, or predict a refusal.
    task automatic plan_append();
        if (n_entries >= MaxBlocks) begin
            plan_q.push_back(mk_plan(ST_FULL, 0, 0, 0, 0, 0, 0, 1'b1));
        end
        else if ({16'd0, entry_cbytes} > 64'hFFFF_FFFF_FFFF - comp_run ||
                 {16'd0, entry_dbytes} > 64'hFFFF_FFFF_FFFF - decomp_run) begin
            plan_q.push_back(mk_plan(ST_OVERFLOW, 0, 0, 0, 0, 0, 0, 1'b1));
        end
        else begin
            start_tab[n_entries] = comp_run;
            csize_tab[n_entries] = entry_cbytes;
            dsize_tab[n_entries] = entry_dbytes;
            dend_tab[n_entries]  = decomp_run + entry_dbytes;
            plan_q.push_back(mk_plan(ST_OK, n_entries[9:0], comp_run, entry_cbytes, 0,
                                     entry_dbytes, decomp_run, 1'b1));
            comp_run   = comp_run + entry_cbytes;
            decomp_run = decomp_run + entry_dbytes;
            n_entries  = n_entries + 1;
        end
    endtask

    // Range query: checks in order, then one plan per spanned block.
    task automatic plan_query();
        logic [63:0] off;
        logic [63:0] len;
        logic [63:0] remaining;
        logic [63:0] dpos;
        logic [63:0] bstart;
        logic [63:0] skip;
        logic [63:0] avail;
        logic [63:0] copy;
        int first;
        int fin;
        off = {16'd0, range_offset};
        len = {16'd0, range_len};
        if (len == 0) begin
            plan_q.push_back(mk_plan(ST_EMPTY, 0, 0, 0, 0, 0, 0, 1'b1));
            return;
        end
        if ({16'd0, dest_room} < len) begin
            plan_q.push_back(mk_plan(ST_DST, 0, 0, 0, 0, 0, 0, 1'b1));
            return;
        end
        if (off + len > {16'd0, decomp_run}) begin
            plan_q.push_back(mk_plan(ST_PAST_END, 0, 0, 0, 0, 0, 0, 1'b1));
            return;
        end
        first = locate_block(off);
        fin   = locate_block(off + len - 1);
        if (fin >= n_entries || first > fin || fin - first + 1 > MaxSpan) begin
            plan_q.push_back(mk_plan(ST_SPAN, 0, 0, 0, 0, 0, 0, 1'b1));
            return;
        end
        remaining = len;
        dpos = 0;
        for (int b = first; b <= fin; b++) begin
            bstart = {16'd0, dend_tab[b]} - dsize_tab[b];
            skip   = off > bstart ? off - bstart : 0;
            avail  = dsize_tab[b] > skip ? dsize_tab[b] - skip : 0;
            copy   = avail < remaining ? avail : remaining;
            plan_q.push_back(mk_plan(ST_OK, b[9:0], start_tab[b], csize_tab[b], skip[31:0],
                                     copy[31:0], dpos[47:0], b == fin));
            dpos      = dpos + copy;
            remaining = remaining - copy;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        plan_t want;
        if (!rst_n) begin
            base_off   = 32'd16;
            n_entries  = '0;
            comp_run   = 48'd16;
            decomp_run = '0;
            plan_q.delete();
            errors     = 0;
            plans_seen = 0;
        end
        else begin
            // Compare the result transaction of this cycle with the oldest prediction.
            if (strobe) begin
                plans_seen++;
                if (plan_q.size() == 0) begin
                    $display("%0t ns: unexpected result, status %0d block %0d",
                             $time, status, block_index);
                    errors++;
                end
                else begin
                    want = plan_q.pop_front();
                    report("status", want.st, status);
                    report("block_index", want.idx, block_index);
                    report("comp_offset", want.coff, comp_offset);
                    report("blk_cbytes", want.csz, blk_cbytes);
                    report("skip_bytes", want.skip, skip_bytes);
                    report("copy_bytes", want.copy, copy_bytes);
                    report("dst_offset", want.doff, dst_offset);
                    report("last", want.lst, last);
                end
            end

            // Register write; only index 0 exists.
            if (psel && penable && pwrite && pready && paddr == RegBase) begin
                base_off = pwdata;
                if (n_entries == 0)
                    comp_run = {16'd0, pwdata};
            end

            // Accepted request transaction.
            if (start && !busy) begin
                case (req_t'(req_type))
                    REQ_CLEAR: begin
                        n_entries  = '0;
                        comp_run   = {16'd0, base_off};
                        decomp_run = '0;
                        plan_q.push_back(mk_plan(ST_OK, 0, 0, 0, 0, 0, 0, 1'b1));
                    end
                    REQ_APPEND: plan_append();
                    REQ_QUERY:  plan_query();
                    default: ;
                endcase
            end
        end
    end

endmodule

FILE: bench/seek_index_range_planner_core_tb.sv
`timescale 1ns / 1ps
// Testbench top for seek_index_range_planner_core: clock, reset, request and APB
// stimulus, and the verdict. Depends on sirp_pkg, the core and sirp_plan_checker.
module seek_index_range_planner_core_tb;
    import sirp_pkg::*;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         start = 1'b0;
    logic         busy;
    logic [1:0]   req_type = REQ_NONE;
    logic [31:0]  entry_cbytes = '0;
    logic [31:0]  entry_dbytes = '0;
    logic [47:0]  range_offset = '0;
    logic [47:0]  range_len = '0;
    logic [47:0]  dest_room = '0;
    logic         strobe;
    logic [2:0]   status;
    logic [9:0]   block_index;
    logic [47:0]  comp_offset;
    logic [31:0]  blk_cbytes;
    logic [31:0]  skip_bytes;
    logic [31:0]  copy_bytes;
    logic [47:0]  dst_offset;
    logic         last;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    int           errors;
    int           pending;
    int           plans_seen;
    logic [10:0]  index_count;
    logic [47:0]  index_total;
    int           requests_sent = 0;

    localparam logic [47:0] Max48 = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] Max32 = 32'hFFFF_FFFF;

    always #2 clk = ~clk;

    seek_index_range_planner_core u_top (.*);

    sirp_plan_checker u_chk (.*);

    function automatic logic [47:0] rand48();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[47:0];
    endfunction

    // Drive one request transaction and hold it until accepted, then idle a while.
    task automatic send(req_t kind, logic [31:0] csz, logic [31:0] dsz,
                        logic [47:0] off, logic [47:0] len, logic [47:0] cap);
        int gap;
        start        <= 1'b1;
        req_type     <= kind;
        entry_cbytes <= csz;
        entry_dbytes <= dsz;
        range_offset <= off;
        range_len    <= len;
        dest_room    <= cap;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        requests_sent++;
        gap = $urandom_range(0, 3);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic append_block(logic [31:0] csz, logic [31:0] dsz);
        send(REQ_APPEND, csz, dsz, rand48(), rand48(), rand48());
    endtask

    task automatic query(logic [47:0] off, logic [47:0] len, logic [47:0] cap);
        send(REQ_QUERY, $urandom, $urandom, off, len, cap);
    endtask

    // Let every predicted result arrive and the sequencer go quiet.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // A query aimed at the current data: mostly valid, some refused.
    task automatic random_query();
        logic [63:0] total;
        logic [63:0] off;
        logic [63:0] len;
        logic [63:0] cap;
        int kind;
        total = {16'd0, index_total};
        kind  = $urandom_range(0, 19);
        off   = total == 0 ? 0 : {$urandom, $urandom} % total;
        case (kind)
            0:       len = 0;
            1:       len = {16'd0, rand48()};
            2, 3:    len = total - off;
            4, 5, 6: len = {$urandom, $urandom} % (total - off + 1);
            default: len = $urandom_range(1, 600);
        endcase
        if (kind == 7)
            off = {16'd0, rand48()};
        case ($urandom_range(0, 9))
            0:       cap = len == 0 ? 0 : len - 1;
            1:       cap = {16'd0, Max48};
            2:       cap = {16'd0, rand48()};
            default: cap = len;
        endcase
        query(off[47:0], len[47:0], cap[47:0]);
    endtask

    // One random phase: fill up to a target block count, mixing in queries and noise.
    task automatic random_phase(int items, int target);
        int pick;
        for (int n = 0; n < items; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
                send(REQ_NONE, $urandom, $urandom, rand48(), rand48(), rand48());
            else if (pick < 5)
                send(REQ_CLEAR, $urandom, $urandom, rand48(), rand48(), rand48());
            else if (index_count < target && pick < 70)
                append_block($urandom, pick < 12 ? 32'd0 :
                             pick < 16 ? $urandom : $urandom_range(1, 300));
            else
                random_query();
        end
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: refusals on an empty index, blocks at the size extremes,
        // zero-size blocks inside a span, an ignored request and a clear.
        query(0, 0, 0);
        query(0, 5, 2);
        query(0, 5, 10);
        append_block(0, 0);
        append_block(100, 50);
        append_block(Max32, 0);
        append_block(7, 0);
        append_block(3, 80);
        append_block(1, Max32);
        query(0, 1, 1);
        query(40, 100, 100);
        query(0, index_total, Max48);
        query(49, 2, 2);
        query(Max48, Max48, Max48);
        query(130, 0, Max48);
        send(REQ_NONE, Max32, Max32, Max48, Max48, Max48);
        send(REQ_CLEAR, 0, 0, 0, 0, 0);
        append_block(5, 5);
        query(0, 5, 5);
        drain();

        // Base offset zero after a write to an unused address, then a random phase.
        apb_write(3'd4, $urandom);
        apb_write(3'd0, 32'd0);
        send(REQ_CLEAR, 0, 0, 0, 0, 0);
        random_phase(60, 40);
        drain();

        apb_write(3'd0, Max32);
        send(REQ_CLEAR, 0, 0, 0, 0, 0);
        random_phase(120, 150);
        drain();
        apb_write(3'd0, 32'd0);

        // Base written while the index holds entries: applies at the next clear.
        apb_write(3'd0, $urandom);
        random_phase(60, 150);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            apb_write(3'd0, $urandom);
            send(REQ_CLEAR, 0, 0, 0, 0, 0);
            random_phase(65, 20 + 40 * ph);
            drain();
        end

        repeat (50) @(posedge clk);
        $display("Covered %0d requests and %0d result transactions", requests_sent,
                 plans_seen);
        $display("across base offset extremes, zero-size blocks, spans and refusal cases.");
        if (errors == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Timeout with %0d results outstanding", pending);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: sim.f
rtl/sirp_pkg.sv
rtl/sirp_entry_ram.sv
rtl/sirp_seq.sv
rtl/seek_index_range_planner_core.sv
rtl/sirp_checker.sv
bench/sirp_plan_checker.sv
bench/seek_index_range_planner_core_tb.sv
